FILE: rtl/core/adaptive_gravity_compensation_assert.svh
// Assertion macros for the adaptive gravity compensation block.
`ifndef ADAPTIVE_GRAVITY_COMPENSATION_ASSERT_SVH
`define ADAPTIVE_GRAVITY_COMPENSATION_ASSERT_SVH
`ifndef SYNTHESIS
`define AGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adaptive_gravity_compensation: assertion failed");
`define AGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adaptive_gravity_compensation: assertion failed");
`else
`define AGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/agc_pkg.sv
`default_nettype none

package agc_pkg;

  localparam int unsigned SINE_TABLE_DEPTH_DEF = 256;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OP_A_W  = 37;
  localparam int OP_B_W  = 18;
  localparam int PROD_W  = OP_A_W + OP_B_W;
  localparam int SLIDE_W = 35;
  localparam int SAT_W   = 40;

  localparam int RAD_TO_TURN = 166886;
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int ONE_Q14 = 16384;

  localparam logic [15:0] LAMBDA_RESET    = 16'd2048;
  localparam logic [15:0] GAIN_HIP_RESET  = 16'd19661;
  localparam logic [15:0] GAIN_KNEE_RESET = 16'd5243;
  localparam logic signed [31:0] EST_RESET = 32'sd6553600;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAMBDA0,
    CFG_LAMBDA1,
    CFG_GAIN_HIP,
    CFG_GAIN_KNEE
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0] angle0;
    logic signed [15:0] angle1;
    logic signed [15:0] rate0;
    logic signed [15:0] rate1;
    logic signed [15:0] target_angle0;
    logic signed [15:0] target_angle1;
    logic signed [15:0] target_rate0;
    logic signed [15:0] target_rate1;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] torque0;
    logic signed [31:0] torque1;
    logic signed [31:0] estimate_hip;
    logic signed [31:0] estimate_knee;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -40'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/adaptive_gravity_compensation.sv
// Adaptive gravity compensation for a two-link leg.
// Input channel (in_valid_i / in_stall_o / in_data_i): one item holds measured and
// desired angles (Q3.12) and rates (Q5.10) of both joints. It is taken at an edge
// with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i / out_data_o): one result per item with
// both torque commands and the two updated gravity estimates, all Q15.16.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (lambda0, lambda1,
// hip gain, knee gain); write only while no item is in flight.
// All arithmetic runs through one 37x18 signed multiplier, registered, plus a
// quarter-wave sine ROM with registered read. An item needs twelve multiplies, each
// with an issue and a use step, and two ROM waits. A new item is taken only once the
// result of the last one has been written to the output register.
// The next item is taken while a result still waits; it completes only once the
// output register is free, so a stalled receiver holds the block at its last step.
// Reset restores the estimates to 100.0 and the registers to their defaults; the
// sine table is constant and needs no fill.
`default_nettype none
`include "adaptive_gravity_compensation_assert.svh"

module adaptive_gravity_compensation #(
  parameter int unsigned SINE_TABLE_DEPTH = agc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  agc_pkg::in_item_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output agc_pkg::out_item_t                  out_data_o,
  input  logic                                cfg_we_i,
  input  logic [agc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [agc_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int A_W   = agc_pkg::OP_A_W;
  localparam int B_W   = agc_pkg::OP_B_W;
  localparam int P_W   = agc_pkg::PROD_W;
  localparam int S_W   = agc_pkg::SLIDE_W;
  localparam int SS_W  = S_W + 1;
  localparam int SAT_W = agc_pkg::SAT_W;
  localparam int D_W   = P_W - 20;
  localparam int ACC_W = 48;
  localparam int TOT_W = ACC_W + 2;
  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int POS_W = IDX_W + 1;
  localparam int SUM_W = IDX_W + 31;
  localparam logic [SUM_W-1:0] HALF_POS = SUM_W'(1) << 29;
  localparam logic [POS_W-1:0] DEPTH_P  = POS_W'(SINE_TABLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_USE,
    ST_ROM,
    ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_S0,
    OP_S1,
    OP_PH0,
    OP_POS0,
    OP_PH1,
    OP_POS1,
    OP_PHIP,
    OP_EHIP,
    OP_PKNEE,
    OP_EKNEE,
    OP_T0,
    OP_T1
  } op_e;

  state_e                   state_q;
  op_e                      op_q;
  agc_pkg::in_item_t        item_q;
  logic [15:0]              lambda0_q, lambda1_q, gain_hip_q, gain_knee_q;
  logic signed [31:0]       est_hip_q, est_knee_q;
  logic signed [S_W-1:0]    s0_q, s1_q;
  logic [1:0]               quad_q;
  logic [29:0]              frac_q;
  logic                     full_q;
  logic signed [15:0]       sin0_q, sin1_q;
  logic signed [A_W-1:0]    p_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [31:0]       tau0_q, tau1_q;
  agc_pkg::out_item_t       out_q;
  logic                     out_valid_q;

  logic signed [A_W-1:0]    op_a;
  logic signed [B_W-1:0]    op_b;
  logic signed [P_W-1:0]    prod;
  logic signed [16:0]       adiff0, adiff1, rdiff0, rdiff1, ang_sum, rdiff_sel;
  logic signed [SS_W-1:0]   s_sum;
  logic signed [S_W-1:0]    s_new;
  logic [SUM_W-1:0]         pos_sum;
  logic [POS_W-1:0]         pos, pos_k;
  logic [IDX_W-1:0]         rom_addr;
  logic [15:0]              rom_data, mag;
  logic signed [15:0]       sin_new;
  logic signed [A_W-1:0]    p_new;
  logic signed [D_W-1:0]    d_new;
  logic signed [31:0]       est_sel, est_new;
  logic signed [SAT_W-1:0]  est_sum;
  logic signed [ACC_W-1:0]  tk;
  logic signed [TOT_W-1:0]  tot, n0, nk;
  logic signed [31:0]       tau0_new, tau1_new;

  assign adiff0  = 17'(item_q.angle0) - 17'(item_q.target_angle0);
  assign adiff1  = 17'(item_q.angle1) - 17'(item_q.target_angle1);
  assign rdiff0  = 17'(item_q.rate0) - 17'(item_q.target_rate0);
  assign rdiff1  = 17'(item_q.rate1) - 17'(item_q.target_rate1);
  assign ang_sum = 17'(item_q.angle0) + 17'(item_q.angle1);
  assign s_sum   = SS_W'(s0_q) + SS_W'(s1_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (op_q)
      OP_S0: begin
        op_a = A_W'(adiff0);
        op_b = {2'b00, lambda0_q};
      end
      OP_S1: begin
        op_a = A_W'(adiff1);
        op_b = {2'b00, lambda1_q};
      end
      OP_PH0: begin
        op_a = A_W'(agc_pkg::RAD_TO_TURN);
        op_b = B_W'(item_q.angle0);
      end
      OP_PH1: begin
        op_a = A_W'(agc_pkg::RAD_TO_TURN);
        op_b = B_W'(ang_sum);
      end
      OP_POS0, OP_POS1: begin
        op_a = {(A_W - 30)'(0), frac_q};
        op_b = B_W'(SINE_TABLE_DEPTH);
      end
      OP_PHIP: begin
        op_a = A_W'(s0_q);
        op_b = B_W'(sin0_q);
      end
      OP_EHIP: begin
        op_a = p_q;
        op_b = {2'b00, gain_hip_q};
      end
      OP_PKNEE: begin
        op_a = A_W'(s_sum);
        op_b = B_W'(sin1_q);
      end
      OP_EKNEE: begin
        op_a = p_q;
        op_b = {2'b00, gain_knee_q};
      end
      OP_T0: begin
        op_a = A_W'(est_hip_q);
        op_b = B_W'(sin0_q);
      end
      OP_T1: begin
        op_a = A_W'(est_knee_q);
        op_b = B_W'(sin1_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  agc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (state_q == ST_ISSUE),
    .a_i    (op_a),
    .b_i    (op_b),
    .prod_o (prod)
  );

  // sliding variable, Q.20
  assign rdiff_sel = (op_q == OP_S0) ? rdiff0 : rdiff1;
  assign s_new     = $signed(prod[S_W-1:0]) + (S_W'(rdiff_sel) <<< 10);

  // table position, rounded, mirrored in odd quadrants
  assign pos_sum  = prod[SUM_W-1:0] + HALF_POS;
  assign pos      = pos_sum[SUM_W-1:30];
  assign pos_k    = quad_q[0] ? (DEPTH_P - pos) : pos;
  assign rom_addr = pos_k[IDX_W-1:0];

  agc_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign mag     = full_q ? 16'(agc_pkg::ONE_Q14) : rom_data;
  assign sin_new = quad_q[1] ? -$signed(mag) : $signed(mag);

  assign p_new    = $signed(prod[A_W+13:14]);
  assign d_new    = $signed(prod[P_W-1:20]);
  assign est_sel  = (op_q == OP_EHIP) ? est_hip_q : est_knee_q;
  assign est_sum  = SAT_W'(est_sel) + SAT_W'(d_new);
  assign est_new  = agc_pkg::sat32(est_sum);

  assign tk       = $signed(prod[ACC_W-1:0]);
  assign tot      = TOT_W'(acc_q) + TOT_W'(tk);
  assign n0       = -tot;
  assign nk       = -TOT_W'(tk);
  assign tau0_new = agc_pkg::sat32(SAT_W'(n0 >>> 14));
  assign tau1_new = agc_pkg::sat32(SAT_W'(nk >>> 14));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_S0;
      item_q      <= '0;
      lambda0_q   <= agc_pkg::LAMBDA_RESET;
      lambda1_q   <= agc_pkg::LAMBDA_RESET;
      gain_hip_q  <= agc_pkg::GAIN_HIP_RESET;
      gain_knee_q <= agc_pkg::GAIN_KNEE_RESET;
      est_hip_q   <= agc_pkg::EST_RESET;
      est_knee_q  <= agc_pkg::EST_RESET;
      s0_q        <= '0;
      s1_q        <= '0;
      quad_q      <= '0;
      frac_q      <= '0;
      full_q      <= 1'b0;
      sin0_q      <= '0;
      sin1_q      <= '0;
      p_q         <= '0;
      acc_q       <= '0;
      tau0_q      <= '0;
      tau1_q      <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (agc_pkg::cfg_idx_e'(cfg_idx_i))
          agc_pkg::CFG_LAMBDA0:   lambda0_q   <= cfg_data_i;
          agc_pkg::CFG_LAMBDA1:   lambda1_q   <= cfg_data_i;
          agc_pkg::CFG_GAIN_HIP:  gain_hip_q  <= cfg_data_i;
          agc_pkg::CFG_GAIN_KNEE: gain_knee_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            op_q    <= OP_S0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          state_q <= ST_USE;
        end
        ST_USE: begin
          unique case (op_q)
            OP_S0:  s0_q <= s_new;
            OP_S1:  s1_q <= s_new;
            OP_PH0, OP_PH1: begin
              quad_q <= prod[31:30];
              frac_q <= prod[29:0];
            end
            OP_POS0, OP_POS1: full_q <= (pos_k >= DEPTH_P);
            OP_PHIP, OP_PKNEE: p_q <= p_new;
            OP_EHIP:  est_hip_q  <= est_new;
            OP_EKNEE: est_knee_q <= est_new;
            OP_T0:    acc_q <= tk;
            OP_T1: begin
              tau0_q <= tau0_new;
              tau1_q <= tau1_new;
            end
            default: ;
          endcase
          priority if (op_q == OP_POS0 || op_q == OP_POS1) begin
            state_q <= ST_ROM;
          end else if (op_q == OP_T1) begin
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_ISSUE;
            op_q    <= op_e'(op_q + 4'd1);
          end
        end
        ST_ROM: begin
          if (op_q == OP_POS0) begin
            sin0_q <= sin_new;
          end else begin
            sin1_q <= sin_new;
          end
          op_q    <= op_e'(op_q + 4'd1);
          state_q <= ST_ISSUE;
        end
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.torque0       <= tau0_q;
            out_q.torque1       <= tau1_q;
            out_q.estimate_hip  <= est_hip_q;
            out_q.estimate_knee <= est_knee_q;
            out_valid_q         <= 1'b1;
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `AGC_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `AGC_ASSERT_NXT(a_est_hold_idle, clk_i, rst_ni, state_q == ST_IDLE, $stable(est_hip_q) && $stable(est_knee_q))
  `AGC_ASSERT_IMP(a_sine_bound, clk_i, rst_ni, $rose(out_valid_o), sin0_q <= 16'sd16384 && sin0_q >= -16'sd16384 && sin1_q <= 16'sd16384 && sin1_q >= -16'sd16384)

endmodule

`default_nettype wire

FILE: rtl/core/agc_mul.sv
`default_nettype none

module agc_mul (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [agc_pkg::OP_A_W-1:0]    a_i,
  input  logic signed [agc_pkg::OP_B_W-1:0]    b_i,
  output logic signed [agc_pkg::PROD_W-1:0]    prod_o
);

  logic signed [agc_pkg::PROD_W-1:0] prod_q;
  logic signed [agc_pkg::PROD_W-1:0] prod_d;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

FILE: rtl/core/agc_sine_rom.sv
`default_nettype none

module agc_sine_rom #(
  parameter int unsigned SINE_TABLE_DEPTH = agc_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic [$clog2(SINE_TABLE_DEPTH)-1:0] addr_i,
  output logic [15:0]                         data_o
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam logic [IDX_W:0] DEPTH_W = (IDX_W + 1)'(SINE_TABLE_DEPTH);

  // two Taylor terms folded into one Q2.30 power step
  function automatic longint unsigned sq_step(input longint unsigned term,
                                              input longint unsigned x);
    longint unsigned t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  function automatic logic [15:0] sine_entry(input longint unsigned i);
    longint unsigned x;
    longint unsigned term;
    longint          sum;
    x    = i * agc_pkg::PI_Q30 / (2 * SINE_TABLE_DEPTH);
    sum  = longint'(x);
    term = sq_step(x, x) / 6;
    sum  = sum - longint'(term);
    term = sq_step(term, x) / 20;
    sum  = sum + longint'(term);
    term = sq_step(term, x) / 42;
    sum  = sum - longint'(term);
    term = sq_step(term, x) / 72;
    sum  = sum + longint'(term);
    term = sq_step(term, x) / 110;
    sum  = sum - longint'(term);
    term = sq_step(term, x) / 156;
    sum  = sum + longint'(term);
    term = sq_step(term, x) / 210;
    sum  = sum - longint'(term);
    term = sq_step(term, x) / 272;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 32768) >>> 16;
    if (sum > agc_pkg::ONE_Q14) begin
      sum = agc_pkg::ONE_Q14;
    end
    return 16'(sum);
  endfunction

  logic [15:0] rom [SINE_TABLE_DEPTH];
  logic [15:0] data_q;

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    localparam logic [15:0] ENTRY = sine_entry(longint'(g));
    assign rom[g] = ENTRY;
  end

  always_ff @(posedge clk_i) begin
    if ({1'b0, addr_i} < DEPTH_W) begin
      data_q <= rom[addr_i];
    end else begin
      data_q <= '0;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROM_DEPTH = agc_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 60;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int PHASES = 5;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  agc_pkg::in_item_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  agc_pkg::out_item_t out_data_o;
  logic cfg_we_i;
  logic [agc_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [agc_pkg::CFG_DATA_W-1:0] cfg_data_i;

  adaptive_gravity_compensation dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // model state
  logic [15:0] sine_rom [ROM_DEPTH];
  longint hip_est;
  longint knee_est;
  logic [15:0] lam0;
  logic [15:0] lam1;
  logic [15:0] gain_hip;
  logic [15:0] gain_knee;

  agc_pkg::out_item_t pending_torques [$];
  int mismatches;
  int quiet_cycles;
  bit idle_en;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [15:0] sine_entry(input int unsigned idx);
    longint unsigned x;
    longint unsigned term;
    longint acc;
    x = longint'(idx) * agc_pkg::PI_Q30 / (64'd2 * ROM_DEPTH);
    term = x;
    acc = longint'(x);
    for (longint unsigned n = 1; n <= 8; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      if (n[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > agc_pkg::ONE_Q14) acc = agc_pkg::ONE_Q14;
    return acc[15:0];
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sine_lookup(input longint ang);
    logic [31:0] phase;
    longint unsigned frac;
    longint unsigned pos;
    longint mag;
    phase = 32'(ang * agc_pkg::RAD_TO_TURN);
    frac = {34'd0, phase[29:0]};
    pos = (frac * ROM_DEPTH + (64'd1 << 29)) >> 30;
    if (phase[30]) pos = ROM_DEPTH - pos;
    mag = (pos >= ROM_DEPTH) ? longint'(agc_pkg::ONE_Q14) : longint'(sine_rom[pos]);
    return phase[31] ? -mag : mag;
  endfunction

  function automatic agc_pkg::out_item_t predict_torques(input agc_pkg::in_item_t it);
    longint s0;
    longint s1;
    longint sn0;
    longint sn1;
    longint t_knee;
    agc_pkg::out_item_t r;
    s0 = (longint'(it.rate0) - longint'(it.target_rate0)) * 1024
         + longint'(lam0) * (longint'(it.angle0) - longint'(it.target_angle0));
    s1 = (longint'(it.rate1) - longint'(it.target_rate1)) * 1024
         + longint'(lam1) * (longint'(it.angle1) - longint'(it.target_angle1));
    sn0 = sine_lookup(longint'(it.angle0));
    sn1 = sine_lookup(longint'(it.angle0) + longint'(it.angle1));
    hip_est = clamp32(hip_est + ((longint'(gain_hip) * ((sn0 * s0) >>> 14)) >>> 20));
    knee_est = clamp32(knee_est
                       + ((longint'(gain_knee) * ((sn1 * (s0 + s1)) >>> 14)) >>> 20));
    t_knee = sn1 * knee_est;
    r.torque0 = 32'(clamp32((-(sn0 * hip_est + t_knee)) >>> 14));
    r.torque1 = 32'(clamp32((-t_knee) >>> 14));
    r.estimate_hip = 32'(hip_est);
    r.estimate_knee = 32'(knee_est);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (!idle_en) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  function automatic agc_pkg::in_item_t make_item(input int a0, a1, r0, r1,
                                                  ta0, ta1, tr0, tr1);
    agc_pkg::in_item_t it;
    it.angle0 = 16'(a0);
    it.angle1 = 16'(a1);
    it.rate0 = 16'(r0);
    it.rate1 = 16'(r1);
    it.target_angle0 = 16'(ta0);
    it.target_angle1 = 16'(ta1);
    it.target_rate0 = 16'(tr0);
    it.target_rate1 = 16'(tr1);
    return it;
  endfunction

  // mostly plausible tracking states, some fully random
  function automatic agc_pkg::in_item_t rand_item();
    int a0;
    int a1;
    int r0;
    int r1;
    if ($urandom_range(0, 9) < 3) begin
      return agc_pkg::in_item_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end
    a0 = $urandom_range(0, 25736) - 12868;
    a1 = $urandom_range(0, 25736) - 12868;
    r0 = $urandom_range(0, 8192) - 4096;
    r1 = $urandom_range(0, 8192) - 4096;
    return make_item(a0, a1, r0, r1,
                     a0 + $urandom_range(0, 1024) - 512, a1 + $urandom_range(0, 1024) - 512,
                     r0 + $urandom_range(0, 2048) - 1024, r1 + $urandom_range(0, 2048) - 1024);
  endfunction

  task automatic send_item(input agc_pkg::in_item_t item);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_torques.push_back(predict_torques(item));
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_torques.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_gains(input logic [15:0] l0, l1, gh, gk);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= agc_pkg::CFG_LAMBDA0;
    cfg_data_i <= l0;
    @(posedge clk_i);
    cfg_idx_i <= agc_pkg::CFG_LAMBDA1;
    cfg_data_i <= l1;
    @(posedge clk_i);
    cfg_idx_i <= agc_pkg::CFG_GAIN_HIP;
    cfg_data_i <= gh;
    @(posedge clk_i);
    cfg_idx_i <= agc_pkg::CFG_GAIN_KNEE;
    cfg_data_i <= gk;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lam0 = l0;
    lam1 = l1;
    gain_hip = gh;
    gain_knee = gk;
  endtask

  task automatic test_field_extremes();
    send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(make_item(32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
    send_item(make_item(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
  endtask

  // quadrant edges and angles past one turn
  task automatic test_angle_wrap();
    send_item(make_item(6434, 0, 100, -100, 6400, 0, 0, 0));
    send_item(make_item(12868, 6434, -200, 50, 12868, 6434, 0, 0));
    send_item(make_item(19302, -6434, 0, 0, 19000, -6000, 10, 10));
    send_item(make_item(25736, 25736, 300, 300, 25736, 25736, 0, 0));
    send_item(make_item(-6434, -12868, 0, 0, -6434, -12868, -50, 50));
    send_item(make_item(32767, 32767, 1, 1, 0, 0, 0, 0));
  endtask

  // zero adaptation rates: estimates must hold
  task automatic test_zero_gains();
    set_gains(16'hffff, 16'hffff, 16'h0000, 16'h0000);
    repeat (3) send_item(rand_item());
  endtask

  // full gains drive the estimates and torques into their limits
  task automatic test_saturation();
    set_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff);
    repeat (8) send_item(make_item(6434, 0, 32767, 32767, -32768, -32768, -32768, -32768));
    repeat (2) send_item(make_item(-6434, 0, -32768, -32768, 32767, 32767, 32767, 32767));
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_gains(agc_pkg::LAMBDA_RESET, agc_pkg::LAMBDA_RESET,
                     agc_pkg::GAIN_HIP_RESET, agc_pkg::GAIN_KNEE_RESET);
        1: set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        2: set_gains(16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                     16'($urandom_range(0, 4096)), 16'($urandom_range(0, 4096)));
        3: set_gains(16'hffff, 16'h0000, 16'h0001, 16'hffff);
        default: set_gains(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
                           16'($urandom_range(0, 2000)));
      endcase
      idle_en = (ph != 2);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 1 && n == ITEMS_PER_PHASE / 2) drain();
        send_item(rand_item());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_torques.size() == 0) begin
        $display("%0t: result with nothing pending: %h", $time, out_data_o);
        mismatches++;
      end else begin
        agc_pkg::out_item_t want;
        want = pending_torques.pop_front();
        if (out_data_o.torque0 !== want.torque0) begin
          $display("%0t: torque0 expected %0d got %0d", $time, want.torque0, out_data_o.torque0);
          mismatches++;
        end
        if (out_data_o.torque1 !== want.torque1) begin
          $display("%0t: torque1 expected %0d got %0d", $time, want.torque1, out_data_o.torque1);
          mismatches++;
        end
        if (out_data_o.estimate_hip !== want.estimate_hip) begin
          $display("%0t: estimate_hip expected %0d got %0d", $time, want.estimate_hip,
                   out_data_o.estimate_hip);
          mismatches++;
        end
        if (out_data_o.estimate_knee !== want.estimate_knee) begin
          $display("%0t: estimate_knee expected %0d got %0d", $time, want.estimate_knee,
                   out_data_o.estimate_knee);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int n;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      n = pick_gap();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= agc_pkg::CFG_LAMBDA0;
    cfg_data_i <= '0;
    idle_en = 1'b1;
    for (int i = 0; i < ROM_DEPTH; i++) sine_rom[i] = sine_entry(i);
    hip_est = agc_pkg::EST_RESET;
    knee_est = agc_pkg::EST_RESET;
    lam0 = agc_pkg::LAMBDA_RESET;
    lam1 = agc_pkg::LAMBDA_RESET;
    gain_hip = agc_pkg::GAIN_HIP_RESET;
    gain_knee = agc_pkg::GAIN_KNEE_RESET;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_angle_wrap();
    test_zero_gains();
    test_saturation();
    test_random_traffic();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
